FILE: src/cdq_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque block.
// -----------------------------------------------------------------------------
package cdq_pkg;

   // Width of one stored word and of the occupancy field.
   localparam int WordW = 32;
   localparam int OccW  = 4;

   // Value reported for a push or a refused operation.
   localparam logic signed [WordW-1:0] PopNone = {WordW{1'b1}};

   // Operation codes of an input item.
   typedef enum logic [1:0] {
      OP_PUSH_FRONT = 2'd0,
      OP_PUSH_REAR  = 2'd1,
      OP_POP_FRONT  = 2'd2,
      OP_POP_REAR   = 2'd3
   } op_type;

   // Status codes of a result item.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage

FILE: src/cdq_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cdq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// -----------------------------------------------------------------------------
module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; the read data is registered and valid in the cycle after the address.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/circular_deque.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed words kept in a circular RAM.
// -----------------------------------------------------------------------------
// Usage:
// An item is accepted at a rising edge where start is high and busy is low.
// The item carries an operation (push front, push rear, pop front, pop rear)
// and a word that pushes store. busy is high only while reset is held, so
// outside reset one item can be accepted in every cycle.
// Each item produces exactly one result in the cycle after it is accepted:
// rsp_strobe is high for that single cycle, with the popped word, a status
// and the occupancy after the operation. A push, or any refused item,
// reports all ones as the popped word. A push on a full deque and a pop on
// an empty deque are refused and leave the contents unchanged.
// Throughput is one item per cycle. The result word comes from the registered
// read of the entry RAM, which is issued at the accepting edge while the
// pointers update at the same edge.
// Reset clears the front pointer, the count and the strobe; the RAM is not
// cleared, since an entry is only read after a push wrote it.
// The receiver cannot stall: each result must be taken in its strobe cycle.
// -----------------------------------------------------------------------------
module circular_deque #(
   parameter int DEPTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  cdq_pkg::op_type                   req_op,
   input  logic signed [cdq_pkg::WordW-1:0]  req_push_value,
   output logic                              rsp_strobe,
   output logic signed [cdq_pkg::WordW-1:0]  rsp_pop_value,
   output cdq_pkg::status_type               rsp_status,
   output logic [cdq_pkg::OccW-1:0]          rsp_occupancy
);

   import cdq_pkg::*;

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);
   localparam int SumW = CntW + 1;
   localparam logic [PtrW-1:0] LastSlot  = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] FullCount = CntW'(DEPTH);
   localparam logic [SumW-1:0] DepthSum  = SumW'(DEPTH);

   logic [PtrW-1:0] front_ff, front_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            strobe_ff;
   logic            pop_ok_ff, pop_ok_in;
   status_type      status_ff, status_in;
   logic [CntW-1:0] occ_ff;

   logic            accept;
   logic            full, empty;
   logic [SumW-1:0] rear_sum, last_sum;
   logic [PtrW-1:0] rear_slot, last_slot, prev_front, next_front;
   logic            wr_en, rd_en;
   logic [PtrW-1:0] wr_addr, rd_addr;
   logic [WordW-1:0] rd_data;
   logic [CntW+OccW-1:0] occ_ext;

   // No item is taken while reset is held.
   assign busy   = reset;
   assign accept = start && !busy;
   assign full   = (count_ff == FullCount);
   assign empty  = (count_ff == '0);

   // Slot arithmetic: front plus count stays below twice the depth.
   always_comb begin
      rear_sum   = SumW'(front_ff) + SumW'(count_ff);
      last_sum   = rear_sum - SumW'(1);
      rear_slot  = (rear_sum >= DepthSum) ? PtrW'(rear_sum - DepthSum) : PtrW'(rear_sum);
      last_slot  = (last_sum >= DepthSum) ? PtrW'(last_sum - DepthSum) : PtrW'(last_sum);
      prev_front = (front_ff == '0) ? LastSlot : front_ff - PtrW'(1);
      next_front = (front_ff == LastSlot) ? '0 : front_ff + PtrW'(1);
   end

   // Operation decode: pointer update and RAM access for the accepted item.
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_DONE;
      pop_ok_in = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = rear_slot;
      rd_addr   = front_ff;
      case (req_op)
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               front_in = prev_front;
               count_in = count_ff + CntW'(1);
               wr_en    = accept;
               wr_addr  = prev_front;
            end
         end
         OP_PUSH_REAR: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               count_in = count_ff + CntW'(1);
               wr_en    = accept;
               wr_addr  = rear_slot;
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_in  = next_front;
               count_in  = count_ff - CntW'(1);
               pop_ok_in = 1'b1;
               rd_en     = accept;
               rd_addr   = front_ff;
            end
         end
         default: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in  = count_ff - CntW'(1);
               pop_ok_in = 1'b1;
               rd_en     = accept;
               rd_addr   = last_slot;
            end
         end
      endcase
   end

   // Control state: pointers, count and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff  <= '0;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
      end
   end

   // Result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         pop_ok_ff <= pop_ok_in;
         status_ff <= status_in;
         occ_ff    <= count_in;
      end
   end

   cdq_ram #(
      .WIDTH(WordW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_push_value),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Result ports; occupancy is cut to its field width.
   assign occ_ext       = {{OccW{1'b0}}, occ_ff};
   assign rsp_strobe    = strobe_ff;
   assign rsp_pop_value = pop_ok_ff ? $signed(rd_data) : PopNone;
   assign rsp_status    = status_ff;
   assign rsp_occupancy = occ_ext[OccW-1:0];

endmodule

FILE: src/cdq_checker.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cdq_checker
// Port-level assertions for the circular deque, bound to the top level.
// -----------------------------------------------------------------------------
module cdq_checker #(
   parameter int DEPTH = 8
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input cdq_pkg::op_type                   req_op,
   input logic signed [cdq_pkg::WordW-1:0]  req_push_value,
   input logic                              rsp_strobe,
   input logic signed [cdq_pkg::WordW-1:0]  rsp_pop_value,
   input cdq_pkg::status_type               rsp_status,
   input logic [cdq_pkg::OccW-1:0]          rsp_occupancy
);

   import cdq_pkg::*;

   localparam logic [OccW+15:0] DepthWide = (OccW + 16)'(DEPTH);
   localparam logic [OccW-1:0]  FullOcc   = DepthWide[OccW-1:0];

   // Every accepted item gives one result in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("accepted item produced no result");

   // No result appears without an accepted item.
   assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("result without an accepted item");

   // A refused item reports all ones as the popped word.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_DONE) |-> rsp_pop_value == PopNone)
      else $error("refused item returned a value");

   // A push refused for fullness reports a full occupancy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> rsp_occupancy == FullOcc)
      else $error("full refusal with wrong occupancy");

   // A pop refused for emptiness reports zero occupancy.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY) |-> rsp_occupancy == '0)
      else $error("empty refusal with nonzero occupancy");

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_checker (.*);
